/* design/uart_rx_line_ring_buffer_defines.svh */
// Assertion macros for the serial receive ring buffer.
// Used by the sequencer file; no other dependencies.
`ifndef UART_RX_LINE_RING_BUFFER_DEFINES_SVH
`define UART_RX_LINE_RING_BUFFER_DEFINES_SVH
`ifndef SYNTH
`define URLRB_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("condition check failed");
`define URLRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define URLRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define URLRB_ASSERT(label, clk, rst, cond)
`define URLRB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define URLRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/urlrb_pkg.sv */
// Shared constants, types and helper functions of the receive ring buffer.
// No dependencies.
`default_nettype none
package urlrb_pkg;
   localparam int DEPTH  = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = 6;
   localparam int BYTE_W = 8;

   localparam logic [CNT_W-1:0]  LINE_MAX   = 6'd63;
   localparam logic [BYTE_W-1:0] TERM_RESET = 8'd10;
   localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

   typedef enum logic [1:0] {
      OP_STORE      = 2'd0,
      OP_READ_LINE  = 2'd1,
      OP_READ_COUNT = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef struct packed {
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic [PTR_W-1:0]  rd_addr;
   } ram_req_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] waiting_count(input logic [PTR_W-1:0] wp,
                                                     input logic [PTR_W-1:0] rp,
                                                     input logic full);
      if (full) begin
         return CNT_W'(DEPTH);
      end else if (wp >= rp) begin
         return CNT_W'(wp) - CNT_W'(rp);
      end else begin
         return CNT_W'(wp) + CNT_W'(DEPTH) - CNT_W'(rp);
      end
   endfunction
endpackage
`default_nettype wire

/* design/urlrb_ram.sv */
// Byte store of the ring buffer: one write port, one read port, registered read data.
// Depends on urlrb_pkg.
`default_nettype none
module urlrb_ram
   import urlrb_pkg::*;
(
   input  wire logic              clock,
   input  wire ram_req_type       ram_req,
   output logic [BYTE_W-1:0]      rd_data
);
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* design/urlrb_seq.sv */
// Sequencer of the ring buffer: pointers, full flag, line count and the read loop.
// Depends on urlrb_pkg and the assertion macro header.
`default_nettype none
`include "uart_rx_line_ring_buffer_defines.svh"
module urlrb_seq
   import urlrb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_op,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              req_blocked,
   input  wire logic [7:0]        req_read_count,
   input  wire logic [BYTE_W-1:0] terminator,
   input  wire logic [BYTE_W-1:0] rd_data,
   output ram_req_type            ram_req,
   output logic                   rsp_strobe,
   output logic [BYTE_W-1:0]      rsp_data_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_last,
   output logic                   rsp_line_found,
   output logic [CNT_W-1:0]       rsp_read_length,
   output logic [CNT_W-1:0]       rsp_bytes_waiting,
   output logic                   rsp_overrun,
   output logic                   rsp_dropped
);
   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  rp_ff, rp_in, wp_ff, wp_in;
   logic              full_ff, full_in;
   logic [CNT_W-1:0]  lines_ff, lines_in;
   logic              is_line_ff, is_line_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              found_ff, found_in;

   logic              res_strobe, res_valid, res_last, res_found, res_dropped;
   logic [BYTE_W-1:0] res_data;
   logic [CNT_W-1:0]  res_len;
   logic              empty, pop;

   logic              rsp_strobe_ff, rsp_byte_valid_ff, rsp_last_ff;
   logic              rsp_line_found_ff, rsp_overrun_ff, rsp_dropped_ff;
   logic [BYTE_W-1:0] rsp_data_byte_ff;
   logic [CNT_W-1:0]  rsp_read_length_ff, rsp_bytes_waiting_ff;

   assign empty = (rp_ff == wp_ff) && !full_ff;
   assign busy  = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      full_in     = full_ff;
      lines_in    = lines_ff;
      is_line_in  = is_line_ff;
      limit_in    = limit_ff;
      len_in      = len_ff;
      found_in    = found_ff;
      res_strobe  = 1'b0;
      res_valid   = 1'b0;
      res_last    = 1'b0;
      res_found   = 1'b0;
      res_dropped = 1'b0;
      res_data    = NUL_BYTE;
      res_len     = '0;
      pop         = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = wp_ff;
      ram_req.wr_data = req_rx_byte;
      ram_req.rd_addr = rp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_STORE: begin
                     res_strobe = 1'b1;
                     res_last   = 1'b1;
                     if (req_blocked || full_ff) begin
                        res_dropped = 1'b1;
                     end else begin
                        ram_req.wr_en = 1'b1;
                        wp_in   = ptr_inc(wp_ff);
                        full_in = (ptr_inc(wp_ff) == rp_ff);
                        if (req_rx_byte == terminator && lines_ff < LINE_MAX) begin
                           lines_in = lines_ff + 1'b1;
                        end
                     end
                  end
                  OP_READ_LINE: begin
                     if (lines_ff != '0) begin
                        state_in   = ST_RUN;
                        is_line_in = 1'b1;
                        limit_in   = CNT_W'(DEPTH);
                        len_in     = '0;
                        found_in   = 1'b0;
                     end else begin
                        // No complete line: a full buffer is flushed, otherwise nothing moves.
                        res_strobe = 1'b1;
                        res_last   = 1'b1;
                        if (full_ff) begin
                           rp_in    = '0;
                           wp_in    = '0;
                           full_in  = 1'b0;
                           lines_in = '0;
                        end
                     end
                  end
                  OP_READ_COUNT: begin
                     state_in   = ST_RUN;
                     is_line_in = 1'b0;
                     limit_in   = (req_read_count > 8'(DEPTH)) ? CNT_W'(DEPTH)
                                                              : req_read_count[CNT_W-1:0];
                     len_in     = '0;
                     found_in   = 1'b0;
                  end
                  default: begin
                     res_strobe = 1'b1;
                     res_last   = 1'b1;
                     rp_in      = '0;
                     wp_in      = '0;
                     full_in    = 1'b0;
                     lines_in   = '0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (!found_ff && !empty && len_ff < limit_ff) begin
               // rd_data holds the entry at rp_ff; fetch the following one meanwhile.
               pop             = 1'b1;
               rp_in           = ptr_inc(rp_ff);
               full_in         = 1'b0;
               ram_req.rd_addr = ptr_inc(rp_ff);
               if (is_line_ff && rd_data == terminator) begin
                  lines_in   = lines_ff - 1'b1;
                  found_in   = 1'b1;
                  res_strobe = 1'b1;
                  res_valid  = 1'b1;
                  res_data   = rd_data;
                  res_len    = len_ff;
               end else if (!(is_line_ff && rd_data == NUL_BYTE)) begin
                  len_in     = len_ff + 1'b1;
                  res_strobe = 1'b1;
                  res_valid  = 1'b1;
                  res_data   = rd_data;
                  res_len    = len_ff + 1'b1;
               end
            end else begin
               res_strobe = 1'b1;
               res_last   = 1'b1;
               res_found  = found_ff;
               res_len    = len_ff;
               state_in   = ST_IDLE;
               if (is_line_ff && !found_ff && empty) begin
                  lines_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rp_ff         <= '0;
         wp_ff         <= '0;
         full_ff       <= 1'b0;
         lines_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff             <= state_in;
         rp_ff                <= rp_in;
         wp_ff                <= wp_in;
         full_ff              <= full_in;
         lines_ff             <= lines_in;
         rsp_strobe_ff        <= res_strobe;
         rsp_data_byte_ff     <= res_data;
         rsp_byte_valid_ff    <= res_valid;
         rsp_last_ff          <= res_last;
         rsp_line_found_ff    <= res_found;
         rsp_read_length_ff   <= res_len;
         rsp_bytes_waiting_ff <= waiting_count(wp_in, rp_in, full_in);
         rsp_overrun_ff       <= full_in;
         rsp_dropped_ff       <= res_dropped;
      end
      is_line_ff <= is_line_in;
      limit_ff   <= limit_in;
      len_ff     <= len_in;
      found_ff   <= found_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_data_byte     = rsp_data_byte_ff;
   assign rsp_byte_valid    = rsp_byte_valid_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_line_found    = rsp_line_found_ff;
   assign rsp_read_length   = rsp_read_length_ff;
   assign rsp_bytes_waiting = rsp_bytes_waiting_ff;
   assign rsp_overrun       = rsp_overrun_ff;
   assign rsp_dropped       = rsp_dropped_ff;

   `URLRB_ASSERT_IMPL(a_full_means_equal_ptrs, clock, reset, full_ff, wp_ff == rp_ff)
   `URLRB_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, !empty && state_ff == ST_RUN)
   `URLRB_ASSERT_NEXT(a_store_answers_next, clock, reset,
                      start && !busy && req_op == OP_STORE, rsp_strobe && rsp_last)
   `URLRB_ASSERT_IMPL(a_overrun_reports_depth, clock, reset, rsp_strobe && rsp_overrun,
                      rsp_bytes_waiting == CNT_W'(DEPTH))
endmodule
`default_nettype wire

/* design/uart_rx_line_ring_buffer.sv */
// Top level of the serial receive ring buffer: terminator register and the
// sequencer with its byte store. Depends on urlrb_pkg, urlrb_ram and urlrb_seq.
//
// Usage: an item (req_op, req_rx_byte, req_blocked, req_read_count) is taken at a
// clock edge where start is high and busy is low. Results appear on the rsp_ ports
// for one cycle each, marked by rsp_strobe; the receiver must take every one.
// Store, clear and a line read with no complete line give a single result in the
// cycle after the item, and busy stays low, so such items can follow every cycle.
// Line and counted reads raise busy. Their first byte passes the registered read
// data of the byte store and then the response registers; further bytes follow
// one per cycle, as the byte store has a single read port, and a NUL skipped by
// a line read gives no result. The closing result (rsp_last) follows the last
// byte, and busy drops with it. The user writes the line terminator through
// csr_write_enable / csr_write_data only while the block is idle; the block has
// no check for this. Reset empties the buffer, clears the full flag and the line
// count and sets the terminator to newline; stored bytes are not cleared.
`default_nettype none
module uart_rx_line_ring_buffer
   import urlrb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_op,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              req_blocked,
   input  wire logic [7:0]        req_read_count,
   input  wire logic              csr_write_enable,
   input  wire logic [BYTE_W-1:0] csr_write_data,
   output logic                   rsp_strobe,
   output logic [BYTE_W-1:0]      rsp_data_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_last,
   output logic                   rsp_line_found,
   output logic [CNT_W-1:0]       rsp_read_length,
   output logic [CNT_W-1:0]       rsp_bytes_waiting,
   output logic                   rsp_overrun,
   output logic                   rsp_dropped
);
   logic [BYTE_W-1:0] term_ff;
   logic [BYTE_W-1:0] rd_data;
   ram_req_type       ram_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= TERM_RESET;
      end else if (csr_write_enable) begin
         term_ff <= csr_write_data;
      end
   end

   urlrb_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   urlrb_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_rx_byte       (req_rx_byte),
      .req_blocked       (req_blocked),
      .req_read_count    (req_read_count),
      .terminator        (term_ff),
      .rd_data           (rd_data),
      .ram_req           (ram_req),
      .rsp_strobe        (rsp_strobe),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last          (rsp_last),
      .rsp_line_found    (rsp_line_found),
      .rsp_read_length   (rsp_read_length),
      .rsp_bytes_waiting (rsp_bytes_waiting),
      .rsp_overrun       (rsp_overrun),
      .rsp_dropped       (rsp_dropped)
   );
endmodule
`default_nettype wire
